/* design/assert_macros.svh */
// assertion macros shared by the tracker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define LPVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in the cycle after a trigger
`define LPVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lpvt_pkg.sv */
// shared types and constants of the lead point velocity tracker
package lpvt_pkg;

    localparam int MAX_AVG_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_NUM_W   = 41;
    localparam int DIV_DEN_W   = 32;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_NONE   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_Z_LOW       = 3'd0;
    localparam logic [2:0] REG_Z_HIGH      = 3'd1;
    localparam logic [2:0] REG_FRONT_LEN   = 3'd2;
    localparam logic [2:0] REG_FRONT_HALFW = 3'd3;
    localparam logic [2:0] REG_REL_LIMIT   = 3'd4;
    localparam logic [2:0] REG_ABS_CAP     = 3'd5;
    localparam logic [2:0] REG_AVG_COUNT   = 3'd6;

    typedef struct packed {
        logic signed [19:0] z_low;
        logic signed [19:0] z_high;
        logic [18:0]        front_length;
        logic [18:0]        front_half_width;
        logic [16:0]        rel_speed_limit;
        logic signed [17:0] abs_speed_cap;
        logic [4:0]         avg_count;
    } cfg_t;

    // one finished frame handed from front to back
    typedef struct packed {
        logic               found;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [31:0]        ft;
        logic signed [17:0] ego;
    } frame_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_CMP,
        BK_DIV_REL,
        BK_HIST,
        BK_AVG,
        BK_DIV_AVG,
        BK_OUT
    } back_state_t;

endpackage

/* design/lead_point_velocity_tracker_unit.sv */
// top level of the lead point velocity tracker with its register port
//
// channel  direction  handshake            word
// points   in         in_valid/in_ready    point, box, frame time, ego speed, last flag
// results  out        out_valid/out_ready  status, avg speed, nearest point
// config   in         apb psel/penable     seven registers at 4*i
//
// points are taken one per cycle while in_ready is high; the filter pipe registers offsets
// and rotation products before the box test; a last point queues one frame word; the back
// handles a frame with up to two passes of the shared one-bit-per-cycle divider
// points stall only when the frame queue holds two or more words; results wait in a register
// no clearing pass after reset; reset restores register defaults
module lead_point_velocity_tracker_unit #(
    parameter int MAX_AVG = lpvt_pkg::MAX_AVG_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [19:0] point_x,
    input  logic signed [19:0] point_y,
    input  logic signed [19:0] point_z,
    input  logic signed [19:0] box_center_x,
    input  logic signed [19:0] box_center_y,
    input  logic signed [15:0] box_cos,
    input  logic signed [15:0] box_sin,
    input  logic [15:0]        box_length,
    input  logic [15:0]        box_width,
    input  logic [31:0]        frame_time,
    input  logic signed [17:0] ego_speed,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [17:0] avg_speed,
    output logic signed [19:0] near_x,
    output logic signed [19:0] near_y,
    output logic signed [19:0] near_z
);

    lpvt_pkg::cfg_t     cfg_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;

    logic                       q_push, q_pop, q_empty;
    lpvt_pkg::frame_t           q_push_word, q_pop_word;
    logic [lpvt_pkg::LVL_W-1:0] q_level;
    lpvt_pkg::div_req_t         div_req;
    lpvt_pkg::div_rsp_t         div_rsp;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.z_low            <= -20'sd500;
            cfg_reg.z_high           <= 20'sd3000;
            cfg_reg.front_length     <= 19'd100000;
            cfg_reg.front_half_width <= 19'd3000;
            cfg_reg.rel_speed_limit  <= 17'd10000;
            cfg_reg.abs_speed_cap    <= 18'sd50000;
            cfg_reg.avg_count        <= 5'd4;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lpvt_pkg::REG_Z_LOW:       cfg_reg.z_low            <= pwdata[19:0];
                lpvt_pkg::REG_Z_HIGH:      cfg_reg.z_high           <= pwdata[19:0];
                lpvt_pkg::REG_FRONT_LEN:   cfg_reg.front_length     <= pwdata[18:0];
                lpvt_pkg::REG_FRONT_HALFW: cfg_reg.front_half_width <= pwdata[18:0];
                lpvt_pkg::REG_REL_LIMIT:   cfg_reg.rel_speed_limit  <= pwdata[16:0];
                lpvt_pkg::REG_ABS_CAP:     cfg_reg.abs_speed_cap    <= pwdata[17:0];
                lpvt_pkg::REG_AVG_COUNT:   cfg_reg.avg_count        <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            lpvt_pkg::REG_Z_LOW:       prdata = {12'd0, cfg_reg.z_low};
            lpvt_pkg::REG_Z_HIGH:      prdata = {12'd0, cfg_reg.z_high};
            lpvt_pkg::REG_FRONT_LEN:   prdata = {13'd0, cfg_reg.front_length};
            lpvt_pkg::REG_FRONT_HALFW: prdata = {13'd0, cfg_reg.front_half_width};
            lpvt_pkg::REG_REL_LIMIT:   prdata = {15'd0, cfg_reg.rel_speed_limit};
            lpvt_pkg::REG_ABS_CAP:     prdata = {14'd0, cfg_reg.abs_speed_cap};
            lpvt_pkg::REG_AVG_COUNT:   prdata = {27'd0, cfg_reg.avg_count};
            default:                   prdata = '0;
        endcase
    end

    lpvt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .box_cos      (box_cos),
        .box_sin      (box_sin),
        .box_length   (box_length),
        .box_width    (box_width),
        .frame_time   (frame_time),
        .ego_speed    (ego_speed),
        .last_point   (last_point),
        .q_level      (q_level),
        .push         (q_push),
        .push_word    (q_push_word)
    );

    lpvt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .pop_word  (q_pop_word),
        .empty     (q_empty),
        .level     (q_level)
    );

    lpvt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lpvt_back #(
        .MAX_AVG (MAX_AVG)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .pop_word  (q_pop_word),
        .pop       (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .avg_speed (avg_speed),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z)
    );

endmodule

/* design/lpvt_queue.sv */
// frame queue between the point front and the speed back
`include "assert_macros.svh"
module lpvt_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  lpvt_pkg::frame_t           push_word,
    input  logic                       pop,
    output lpvt_pkg::frame_t           pop_word,
    output logic                       empty,
    output logic [lpvt_pkg::LVL_W-1:0] level
);

    localparam int DEPTH = lpvt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lpvt_pkg::frame_t            mem_reg [DEPTH];
    logic [PW-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [lpvt_pkg::LVL_W-1:0]  count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + lpvt_pkg::LVL_W'(push) - lpvt_pkg::LVL_W'(pop);
        end
    end

    assign pop_word = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign level    = count_reg;

    `LPVT_ASSERT(a_no_overflow, push |-> (count_reg < lpvt_pkg::LVL_W'(DEPTH)), "queue overflow")
    `LPVT_ASSERT(a_no_underflow, pop |-> (count_reg != '0), "queue underflow")

endmodule

/* design/lpvt_front.sv */
// point front: filters points and keeps the nearest one of each frame
module lpvt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lpvt_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [19:0]         point_x,
    input  logic signed [19:0]         point_y,
    input  logic signed [19:0]         point_z,
    input  logic signed [19:0]         box_center_x,
    input  logic signed [19:0]         box_center_y,
    input  logic signed [15:0]         box_cos,
    input  logic signed [15:0]         box_sin,
    input  logic [15:0]                box_length,
    input  logic [15:0]                box_width,
    input  logic [31:0]                frame_time,
    input  logic signed [17:0]         ego_speed,
    input  logic                       last_point,
    input  logic [lpvt_pkg::LVL_W-1:0] q_level,
    output logic                       push,
    output lpvt_pkg::frame_t           push_word
);

    logic accept;
    logic signed [20:0] px21, py21, fl21, fhw21, fhw21_n;
    logic pre_keep;

    // stage 1
    logic s1_valid_reg;
    logic s1_pre_reg, s1_last_reg;
    logic signed [20:0] s1_dx_reg, s1_dy_reg;
    logic signed [15:0] s1_cs_reg, s1_sn_reg;
    logic [15:0] s1_bl_reg, s1_bw_reg;
    logic signed [19:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [31:0] s1_ft_reg;
    logic signed [17:0] s1_ego_reg;

    // stage 2
    logic s2_valid_reg;
    logic s2_pre_reg, s2_last_reg;
    logic signed [36:0] s2_p1_reg, s2_p2_reg, s2_p3_reg, s2_p4_reg;
    logic [15:0] s2_bl_reg, s2_bw_reg;
    logic signed [19:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [31:0] s2_ft_reg;
    logic signed [17:0] s2_ego_reg;

    // nearest point
    logic best_valid_reg, best_valid_next;
    logic signed [19:0] best_x_reg, best_y_reg, best_z_reg;
    logic signed [19:0] best_x_next, best_y_next, best_z_next;

    logic signed [37:0] u, v;
    logic [37:0] abs_u, abs_v;
    logic keep, take;

    // room for every word that may still come out of the pipe
    assign in_ready = (q_level <= lpvt_pkg::LVL_W'(lpvt_pkg::QUEUE_DEPTH - 3));
    assign accept   = in_valid & in_ready;

    // height band and corridor
    assign px21     = {point_x[19], point_x};
    assign py21     = {point_y[19], point_y};
    assign fl21     = {2'b00, cfg.front_length};
    assign fhw21    = {2'b00, cfg.front_half_width};
    assign fhw21_n  = -fhw21;
    assign pre_keep = (point_z >= cfg.z_low) && (point_z <= cfg.z_high) &&
                      !point_x[19] && (px21 <= fl21) &&
                      (py21 >= fhw21_n) && (py21 <= fhw21);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            best_valid_reg <= best_valid_next;
        end
    end

    // stage 1: offsets from box centre
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pre_reg  <= pre_keep;
            s1_last_reg <= last_point;
            s1_dx_reg   <= px21 - {box_center_x[19], box_center_x};
            s1_dy_reg   <= py21 - {box_center_y[19], box_center_y};
            s1_cs_reg   <= box_cos;
            s1_sn_reg   <= box_sin;
            s1_bl_reg   <= box_length;
            s1_bw_reg   <= box_width;
            s1_px_reg   <= point_x;
            s1_py_reg   <= point_y;
            s1_pz_reg   <= point_z;
            s1_ft_reg   <= frame_time;
            s1_ego_reg  <= ego_speed;
        end
    end

    // stage 2: rotation products
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_pre_reg  <= s1_pre_reg;
            s2_last_reg <= s1_last_reg;
            s2_p1_reg   <= s1_dx_reg * s1_cs_reg;
            s2_p2_reg   <= s1_dy_reg * s1_sn_reg;
            s2_p3_reg   <= s1_dy_reg * s1_cs_reg;
            s2_p4_reg   <= s1_dx_reg * s1_sn_reg;
            s2_bl_reg   <= s1_bl_reg;
            s2_bw_reg   <= s1_bw_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            s2_pz_reg   <= s1_pz_reg;
            s2_ft_reg   <= s1_ft_reg;
            s2_ego_reg  <= s1_ego_reg;
        end
    end

    // stage 3: box test, nearest point, frame word
    always_comb
    begin
        u     = {s2_p1_reg[36], s2_p1_reg} + {s2_p2_reg[36], s2_p2_reg};
        v     = {s2_p3_reg[36], s2_p3_reg} - {s2_p4_reg[36], s2_p4_reg};
        abs_u = u[37] ? 38'(-u) : 38'(u);
        abs_v = v[37] ? 38'(-v) : 38'(v);
        keep  = s2_pre_reg &&
                ({abs_u, 1'b0} < {9'd0, s2_bl_reg, 14'd0}) &&
                ({abs_v, 1'b0} < {9'd0, s2_bw_reg, 14'd0});
        take  = s2_valid_reg && keep && (!best_valid_reg || (s2_px_reg < best_x_reg));

        best_valid_next = best_valid_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_z_next     = best_z_reg;
        if (take)
        begin
            best_valid_next = 1'b1;
            best_x_next     = s2_px_reg;
            best_y_next     = s2_py_reg;
            best_z_next     = s2_pz_reg;
        end

        push            = s2_valid_reg && s2_last_reg;
        push_word.found = best_valid_next;
        push_word.x     = best_x_next;
        push_word.y     = best_y_next;
        push_word.z     = best_z_next;
        push_word.ft    = s2_ft_reg;
        push_word.ego   = s2_ego_reg;

        if (push)
        begin
            best_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        best_z_reg <= best_z_next;
    end

endmodule

/* design/lpvt_divider.sv */
// shared radix-2 restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module lpvt_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpvt_pkg::div_req_t   req,
    output lpvt_pkg::div_rsp_t   rsp
);

    localparam int NW = lpvt_pkg::DIV_NUM_W;
    localparam int DW = lpvt_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg, den_reg;
    logic [NW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DW:0]      shifted, diff;
    logic             ge;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    `LPVT_ASSERT(a_no_restart, req.start |-> !busy_reg, "divider restarted while busy")

endmodule

/* design/lpvt_back.sv */
// speed back: relative speed, clamp, moving average and result word
`include "assert_macros.svh"
module lpvt_back #(
    parameter int MAX_AVG = lpvt_pkg::MAX_AVG_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpvt_pkg::cfg_t            cfg,
    input  logic                      q_empty,
    input  lpvt_pkg::frame_t          pop_word,
    output logic                      pop,
    output lpvt_pkg::div_req_t        div_req,
    input  lpvt_pkg::div_rsp_t        div_rsp,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [17:0]        avg_speed,
    output logic signed [19:0]        near_x,
    output logic signed [19:0]        near_y,
    output logic signed [19:0]        near_z
);

    localparam int IW = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
    localparam int CW = $clog2(MAX_AVG + 1);
    localparam int SW = 18 + CW;
    localparam int NW = lpvt_pkg::DIV_NUM_W;

    lpvt_pkg::back_state_t state_reg, state_next;
    lpvt_pkg::frame_t      word_reg;

    logic [31:0]        prev_time_reg;
    logic signed [19:0] prev_x_reg;
    logic signed [17:0] hist_reg [MAX_AVG];
    logic [CW-1:0]      hcount_reg, hcount_next;
    logic [IW-1:0]      head_reg, head_next;
    logic signed [SW-1:0] hsum_reg, hsum_next;

    logic [31:0]        dt_reg;
    logic signed [20:0] dxp_reg;
    logic [40:0]        prodx_reg;
    logic [48:0]        prodl_reg;
    logic signed [18:0] rel_reg, rel_next;

    logic [1:0]         status_reg, status_next;
    logic signed [17:0] avg_reg, avg_next;

    logic [20:0]        abs_dxp;
    logic [18:0]        qrel;
    logic [17:0]        qavg;
    logic signed [19:0] a_sum, a_clamp, cap20;
    logic signed [17:0] a_val;
    logic [7:0]         n_eff, hcount8;
    logic               drop, hist_we;
    logic [IW+1:0]      old_tmp;
    logic [IW-1:0]      old_idx;
    logic [SW-1:0]      abs_sum;

    // pieces of the speed path
    always_comb
    begin
        abs_dxp = dxp_reg[20] ? 21'(-dxp_reg) : 21'(dxp_reg);
        qrel    = div_rsp.quo[18:0];
        qavg    = div_rsp.quo[17:0];
        a_sum   = {rel_reg[18], rel_reg} + {{2{word_reg.ego[17]}}, word_reg.ego};
        cap20   = {{2{cfg.abs_speed_cap[17]}}, cfg.abs_speed_cap};
        a_clamp = (a_sum > cap20) ? cap20 : a_sum;
        if (a_clamp < -20'sd131072)
        begin
            a_clamp = -20'sd131072;
        end
        a_val   = a_clamp[17:0];

        // effective average length
        n_eff = {3'd0, cfg.avg_count};
        if (n_eff == 8'd0)
        begin
            n_eff = 8'd1;
        end
        else if (n_eff > 8'(MAX_AVG))
        begin
            n_eff = 8'(MAX_AVG);
        end
        hcount8 = 8'(hcount_reg);
        drop    = (hcount8 >= n_eff);

        // oldest entry of the ring
        old_tmp = (IW+2)'(head_reg) + (IW+2)'(MAX_AVG) - (IW+2)'(hcount_reg);
        if (old_tmp >= (IW+2)'(MAX_AVG))
        begin
            old_tmp = old_tmp - (IW+2)'(MAX_AVG);
        end
        old_idx = old_tmp[IW-1:0];

        abs_sum = hsum_reg[SW-1] ? SW'(-hsum_reg) : SW'(hsum_reg);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        div_req     = '0;
        rel_next    = rel_reg;
        status_next = status_reg;
        avg_next    = avg_reg;
        hist_we     = 1'b0;
        hcount_next = hcount_reg;
        head_next   = head_reg;
        hsum_next   = hsum_reg;

        unique case (state_reg)
            lpvt_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = lpvt_pkg::BK_PREP;
                end
            end
            lpvt_pkg::BK_PREP:
            begin
                if (!word_reg.found)
                begin
                    status_next = lpvt_pkg::STAT_NONE;
                    avg_next    = '0;
                    state_next  = lpvt_pkg::BK_OUT;
                end
                else if (hcount_reg == '0)
                begin
                    rel_next   = '0;
                    state_next = lpvt_pkg::BK_HIST;
                end
                else
                begin
                    state_next = lpvt_pkg::BK_MUL;
                end
            end
            lpvt_pkg::BK_MUL:
            begin
                state_next = lpvt_pkg::BK_CMP;
            end
            lpvt_pkg::BK_CMP:
            begin
                if ((dt_reg == '0) || ({8'd0, prodx_reg} > prodl_reg))
                begin
                    status_next = lpvt_pkg::STAT_REJECT;
                    avg_next    = '0;
                    state_next  = lpvt_pkg::BK_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = prodx_reg;
                    div_req.den   = dt_reg;
                    state_next    = lpvt_pkg::BK_DIV_REL;
                end
            end
            lpvt_pkg::BK_DIV_REL:
            begin
                if (div_rsp.done)
                begin
                    rel_next   = dxp_reg[20] ? 19'(-qrel) : qrel;
                    state_next = lpvt_pkg::BK_HIST;
                end
            end
            lpvt_pkg::BK_HIST:
            begin
                hist_we     = 1'b1;
                hsum_next   = hsum_reg - (drop ? SW'(hist_reg[old_idx]) : SW'(0)) + SW'(a_val);
                hcount_next = hcount_reg - CW'(drop) + CW'(1);
                head_next   = (head_reg == IW'(MAX_AVG - 1)) ? '0 : head_reg + 1'b1;
                state_next  = lpvt_pkg::BK_AVG;
            end
            lpvt_pkg::BK_AVG:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(abs_sum);
                div_req.den   = 32'(hcount_reg);
                state_next    = lpvt_pkg::BK_DIV_AVG;
            end
            lpvt_pkg::BK_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next    = hsum_reg[SW-1] ? 18'(-qavg) : 18'(qavg);
                    status_next = lpvt_pkg::STAT_OK;
                    state_next  = lpvt_pkg::BK_OUT;
                end
            end
            lpvt_pkg::BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = lpvt_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lpvt_pkg::BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpvt_pkg::BK_IDLE;
            prev_time_reg <= '0;
            prev_x_reg    <= '0;
            hcount_reg    <= '0;
            head_reg      <= '0;
            hsum_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            hcount_reg <= hcount_next;
            head_reg   <= head_next;
            hsum_reg   <= hsum_next;
            if (hist_we)
            begin
                prev_time_reg <= word_reg.ft;
                prev_x_reg    <= word_reg.x;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= pop_word;
        end
        if (state_reg == lpvt_pkg::BK_PREP)
        begin
            dt_reg  <= word_reg.ft - prev_time_reg;
            dxp_reg <= {word_reg.x[19], word_reg.x} - {prev_x_reg[19], prev_x_reg};
        end
        if (state_reg == lpvt_pkg::BK_MUL)
        begin
            prodx_reg <= 41'(abs_dxp) * 41'(lpvt_pkg::US_PER_S);
            prodl_reg <= 49'(cfg.rel_speed_limit) * 49'(dt_reg);
        end
        if (hist_we)
        begin
            hist_reg[head_reg] <= a_val;
        end
        rel_reg    <= rel_next;
        status_reg <= status_next;
        avg_reg    <= avg_next;
    end

    assign out_valid = (state_reg == lpvt_pkg::BK_OUT);
    assign status    = status_reg;
    assign avg_speed = avg_reg;
    assign near_x    = (status_reg == lpvt_pkg::STAT_NONE) ? 20'sd0 : word_reg.x;
    assign near_y    = (status_reg == lpvt_pkg::STAT_NONE) ? 20'sd0 : word_reg.y;
    assign near_z    = (status_reg == lpvt_pkg::STAT_NONE) ? 20'sd0 : word_reg.z;

    `LPVT_ASSERT(a_hist_bound, hcount_reg <= CW'(MAX_AVG), "history count beyond depth")
    `LPVT_ASSERT(a_pop_idle, pop |-> (state_reg == lpvt_pkg::BK_IDLE), "pop outside idle")
    `LPVT_ASSERT_NEXT(a_pop_prep, pop, state_reg == lpvt_pkg::BK_PREP, "pop not followed by prep")

endmodule
